[rtl/ssd_pkg.sv]
// Shared constants and types for the sample standard deviation unit.
// No dependencies; imported by the top, the divider and the checker.
`default_nettype none
package ssd_pkg;

    localparam int MAX_SAMPLES = 1024;
    localparam int ADDR_W      = $clog2(MAX_SAMPLES);
    localparam int CNT_W       = $clog2(MAX_SAMPLES + 1);
    localparam int SAMPLE_W    = 16;
    localparam int SUM_W       = SAMPLE_W + ADDR_W;
    localparam int DIFF_W      = SAMPLE_W + 2;
    localparam int PROD_W      = 2 * SAMPLE_W;
    // even width so the root search can step two bits at a time
    localparam int SQ_W        = 2 * ((PROD_W + ADDR_W + 1) / 2);
    localparam int DIV_CNT_W   = $clog2(SQ_W + 1);
    localparam int STD_W       = 16;
    localparam int STAT_W      = 2;

    localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
    localparam logic [STAT_W-1:0] ST_TOO_FEW  = 2'd1;
    localparam logic [STAT_W-1:0] ST_CAPACITY = 2'd2;

    typedef struct packed {
        logic              start;
        logic [SQ_W-1:0]   dividend;
        logic [CNT_W-1:0]  divisor;
    } div_req_t;

endpackage
`default_nettype wire

[rtl/sample_std_deviation_unit.sv]
// Sample standard deviation unit, top level.
// Depends on ssd_pkg, ssd_ram (sample store) and ssd_div (shared divider).
//
// Usage:
//   Slave channel: one signed Q3.12 sample per word on s_tdata[15:0];
//   s_tlast marks the final sample of a set. While loading, one word is
//   taken every cycle. Up to 1024 samples are stored; later ones are
//   dropped and the set reports status 2.
//   Master channel: one word per set, std_dev (unsigned Q4.12, saturating)
//   in m_tdata[15:0] and status in m_tdata[17:16] (0 ok, 1 fewer than two
//   samples, 2 capacity exceeded).
//   After the last word, s_tready drops while the result is computed:
//   a divide for the mean, a second pass over the store, a divide for
//   the variance and a root search; both divides use the one bit-serial
//   divider, and the pass reads the single read port of the store. A set
//   with fewer than two samples skips these steps and goes straight to
//   the output register.
//   The result sits in an output register; loading of the next set
//   resumes as soon as it is written there. If the receiver stalls, a
//   following set finishes and waits with s_tready low until the earlier
//   word is taken.
//   Reset clears the sample count, running sum, read counter and output
//   valid; set totals, the squares accumulator and store contents are not cleared.
`default_nettype none
module sample_std_deviation_unit (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // [15:0] sample
    input  wire logic        s_tlast,   // last_sample
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata    // [15:0] std_dev, [17:16] status, zero pad
);
    import ssd_pkg::*;

    localparam logic [2:0] S_LOAD   = 3'd0;
    localparam logic [2:0] S_MEAN   = 3'd1;
    localparam logic [2:0] S_PASS   = 3'd2;
    localparam logic [2:0] S_VDIV   = 3'd3;
    localparam logic [2:0] S_SQRT   = 3'd4;
    localparam logic [2:0] S_FINISH = 3'd5;

    logic [2:0]                state_reg, state_next;
    logic [CNT_W-1:0]          count_reg, count_next;
    logic signed [SUM_W-1:0]   sum_reg, sum_next;
    logic                      ovf_reg, ovf_next;
    logic [CNT_W-1:0]          n_reg, n_next;
    logic signed [SUM_W-1:0]   tsum_reg, tsum_next;
    logic                      tovf_reg, tovf_next;
    logic                      few_reg, few_next;
    logic signed [SAMPLE_W-1:0] mean_reg, mean_next;
    logic                      div_start_reg, div_start_next;
    logic [CNT_W-1:0]          rd_cnt_reg, rd_cnt_next;
    logic                      v1_reg, v1_next;
    logic                      v2_reg, v2_next;
    logic                      v3_reg, v3_next;
    logic signed [DIFF_W-1:0]  diff_reg, diff_next;
    logic [PROD_W-1:0]         prod_reg, prod_next;
    logic [SQ_W-1:0]           acc_reg, acc_next;
    logic [SQ_W-1:0]           sq_v_reg, sq_v_next;
    logic [SQ_W-1:0]           root_reg, root_next;
    logic [SQ_W-1:0]           bit_reg, bit_next;
    logic                      m_tvalid_reg, m_tvalid_next;
    logic [STD_W-1:0]          std_reg, std_next;
    logic [STAT_W-1:0]         stat_reg, stat_next;

    logic                      accept;
    logic                      room;
    logic signed [SUM_W-1:0]   sum_add;
    logic [CNT_W-1:0]          count_inc;
    logic [SUM_W-1:0]          tsum_mag;
    logic [SAMPLE_W-1:0]       mean_mag;
    logic [SAMPLE_W-1:0]       ram_rdata;
    logic signed [2*DIFF_W-1:0] sq_full;
    logic [SQ_W-1:0]           root_trial;
    logic                      issue;
    div_req_t                  div_req;
    logic                      div_done;
    logic [SQ_W-1:0]           div_q;

    assign s_tready  = (state_reg == S_LOAD);
    assign accept    = s_tvalid && s_tready;
    assign room      = (count_reg < CNT_W'(MAX_SAMPLES));
    assign count_inc = count_reg + 1'b1;
    assign sum_add   = sum_reg + SUM_W'($signed(s_tdata[SAMPLE_W-1:0]));
    assign tsum_mag  = tsum_reg[SUM_W-1] ? SUM_W'(-tsum_reg) : SUM_W'(tsum_reg);
    assign mean_mag  = div_q[SAMPLE_W-1:0];
    assign sq_full   = diff_reg * diff_reg;
    assign root_trial = root_reg + bit_reg;
    assign issue     = (state_reg == S_PASS) && (rd_cnt_reg < n_reg);

    always_comb
    begin
        div_req.start    = div_start_reg;
        div_req.dividend = (state_reg == S_MEAN) ? SQ_W'(tsum_mag) : acc_reg;
        div_req.divisor  = (state_reg == S_MEAN) ? n_reg : n_reg - 1'b1;
    end

    ssd_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (MAX_SAMPLES)
    ) u_store (
        .clk   (clk),
        .we    (accept && room),
        .waddr (count_reg[ADDR_W-1:0]),
        .wdata (s_tdata[SAMPLE_W-1:0]),
        .raddr (rd_cnt_reg[ADDR_W-1:0]),
        .rdata (ram_rdata)
    );

    ssd_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (div_req),
        .done     (div_done),
        .quotient (div_q)
    );

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        sum_next       = sum_reg;
        ovf_next       = ovf_reg;
        n_next         = n_reg;
        tsum_next      = tsum_reg;
        tovf_next      = tovf_reg;
        few_next       = few_reg;
        mean_next      = mean_reg;
        div_start_next = 1'b0;
        rd_cnt_next    = rd_cnt_reg;
        v1_next        = issue;
        v2_next        = v1_reg;
        v3_next        = v2_reg;
        diff_next      = DIFF_W'($signed(ram_rdata)) - DIFF_W'(mean_reg);
        prod_next      = sq_full[PROD_W-1:0];
        acc_next       = acc_reg;
        sq_v_next      = sq_v_reg;
        root_next      = root_reg;
        bit_next       = bit_reg;
        m_tvalid_next  = m_tvalid_reg && !m_tready;
        std_next       = std_reg;
        stat_next      = stat_reg;

        unique case (state_reg)
            S_LOAD:
            begin
                if (accept)
                begin
                    if (room)
                    begin
                        count_next = count_inc;
                        sum_next   = sum_add;
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                    if (s_tlast)
                    begin
                        n_next     = room ? count_inc : count_reg;
                        tsum_next  = room ? sum_add : sum_reg;
                        tovf_next  = ovf_reg || !room;
                        count_next = '0;
                        sum_next   = '0;
                        ovf_next   = 1'b0;
                        if ((room ? count_inc : count_reg) < CNT_W'(2))
                        begin
                            few_next   = 1'b1;
                            root_next  = '0;
                            state_next = S_FINISH;
                        end
                        else
                        begin
                            few_next       = 1'b0;
                            div_start_next = 1'b1;
                            state_next     = S_MEAN;
                        end
                    end
                end
            end
            S_MEAN:
            begin
                if (div_done)
                begin
                    mean_next   = tsum_reg[SUM_W-1] ? $signed(-mean_mag)
                                                    : $signed(mean_mag);
                    rd_cnt_next = '0;
                    acc_next    = '0;
                    state_next  = S_PASS;
                end
            end
            S_PASS:
            begin
                if (issue)
                begin
                    rd_cnt_next = rd_cnt_reg + 1'b1;
                end
                if (v3_reg)
                begin
                    acc_next = acc_reg + SQ_W'(prod_reg);
                end
                if (!issue && !v1_reg && !v2_reg && !v3_reg)
                begin
                    div_start_next = 1'b1;
                    state_next     = S_VDIV;
                end
            end
            S_VDIV:
            begin
                if (div_done)
                begin
                    sq_v_next  = div_q;
                    root_next  = '0;
                    bit_next   = SQ_W'(1) << (SQ_W - 2);
                    state_next = S_SQRT;
                end
            end
            S_SQRT:
            begin
                if (bit_reg == '0)
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    if (sq_v_reg >= root_trial)
                    begin
                        sq_v_next = sq_v_reg - root_trial;
                        root_next = (root_reg >> 1) + bit_reg;
                    end
                    else
                    begin
                        root_next = root_reg >> 1;
                    end
                    bit_next = bit_reg >> 2;
                end
            end
            S_FINISH:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    std_next      = (root_reg > SQ_W'({STD_W{1'b1}})) ? {STD_W{1'b1}}
                                                                     : root_reg[STD_W-1:0];
                    priority if (few_reg)
                    begin
                        stat_next = ST_TOO_FEW;
                    end
                    else if (tovf_reg)
                    begin
                        stat_next = ST_CAPACITY;
                    end
                    else
                    begin
                        stat_next = ST_OK;
                    end
                    state_next = S_LOAD;
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_LOAD;
            count_reg     <= '0;
            sum_reg       <= '0;
            ovf_reg       <= 1'b0;
            div_start_reg <= 1'b0;
            rd_cnt_reg    <= '0;
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            m_tvalid_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            sum_reg       <= sum_next;
            ovf_reg       <= ovf_next;
            div_start_reg <= div_start_next;
            rd_cnt_reg    <= rd_cnt_next;
            v1_reg        <= v1_next;
            v2_reg        <= v2_next;
            v3_reg        <= v3_next;
            m_tvalid_reg  <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg    <= n_next;
        tsum_reg <= tsum_next;
        tovf_reg <= tovf_next;
        few_reg  <= few_next;
        mean_reg <= mean_next;
        diff_reg <= diff_next;
        prod_reg <= prod_next;
        acc_reg  <= acc_next;
        sq_v_reg <= sq_v_next;
        root_reg <= root_next;
        bit_reg  <= bit_next;
        std_reg  <= std_next;
        stat_reg <= stat_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(24 - STD_W - STAT_W){1'b0}}, stat_reg, std_reg};

endmodule
`default_nettype wire

[rtl/ssd_ram.sv]
// Generic single-clock RAM: one write port, one read port, registered read.
// Standalone; no package dependency.
`default_nettype none
module ssd_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

[rtl/ssd_div.sv]
// Iterative restoring divider, one quotient bit per cycle.
// Depends on ssd_pkg (widths, div_req_t).
`default_nettype none
module ssd_div (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire ssd_pkg::div_req_t           req,
    output logic                             done,
    output logic [ssd_pkg::SQ_W-1:0]         quotient
);
    import ssd_pkg::*;

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [SQ_W-1:0]      q_reg, q_next;
    logic [CNT_W-1:0]     rem_reg, rem_next;
    logic [CNT_W-1:0]     dvs_reg, dvs_next;
    logic [CNT_W:0]       trial;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        q_next    = q_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        trial     = {rem_reg, q_reg[SQ_W-1]};
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = DIV_CNT_W'(SQ_W);
            q_next    = req.dividend;
            rem_next  = '0;
            dvs_next  = req.divisor;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, dvs_reg})
            begin
                rem_next = CNT_W'(trial - {1'b0, dvs_reg});
                q_next   = {q_reg[SQ_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[CNT_W-1:0];
                q_next   = {q_reg[SQ_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == DIV_CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg   <= q_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule
`default_nettype wire

[rtl/ssd_checker.sv]
// Port-level checks for the sample standard deviation unit, bound to the top.
// Depends on ssd_pkg for the status codes.
`default_nettype none
module ssd_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic [15:0] s_tdata,
    input wire logic        s_tlast,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [23:0] m_tdata
);
    import ssd_pkg::*;

    // a held result word keeps its contents
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word changed while stalled");

    // the end of a set always leaves the loading phase, dropping s_tready right after the last word
    a_last_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && s_tlast |=> !s_tready)
        else $error("sample taken right after the last word of a set");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[17:16] == ST_OK) || (m_tdata[17:16] == ST_TOO_FEW)
                     || (m_tdata[17:16] == ST_CAPACITY))
        else $error("undefined status code");

    a_too_few_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata[17:16] == ST_TOO_FEW) |-> (m_tdata[15:0] == 16'd0))
        else $error("nonzero deviation for a set of fewer than two samples");

endmodule

bind sample_std_deviation_unit ssd_checker u_ssd_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
`default_nettype wire
